// ===== hdl/gbfp_pkg.sv =====
// ----------------------------------------------------------------------------
// gbfp_pkg
// Shared types and constants for the binary GNSS frame parser.
// ----------------------------------------------------------------------------
package gbfp_pkg;

  localparam int unsigned STORE_BYTES = 256;
  localparam int unsigned FRAME_BYTES = 92;
  localparam int unsigned HDR_BYTES   = 4;

  localparam int unsigned STORE_CW = $clog2(STORE_BYTES + 1);
  localparam int unsigned FRAME_AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // a matching frame must fit in the store to be accepted at all
  localparam bit FRAME_FITS = (FRAME_BYTES + HDR_BYTES) <= STORE_BYTES;

  localparam logic [7:0] SYNC_FIRST       = 8'hB5;
  localparam logic [7:0] SYNC_SECOND      = 8'h62;
  localparam logic [7:0] WANTED_CLASS_RST = 8'h01;
  localparam logic [7:0] WANTED_ID_RST    = 8'h07;

  typedef enum logic [2:0] {
    PS_SYNC1   = 3'd0,
    PS_SYNC2   = 3'd1,
    PS_HEADER  = 3'd2,
    PS_PAYLOAD = 3'd3,
    PS_SUM_A   = 3'd4,
    PS_SUM_B   = 3'd5
  } parse_state_e;

  typedef enum logic [1:0] {
    STAT_HUNT    = 2'd0,
    STAT_PARSING = 2'd1,
    STAT_DONE    = 2'd2,
    STAT_READ    = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WANTED_CLASS = 2'd0,
    CFG_WANTED_ID    = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    OP_PARSE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  // one classified request as it travels from the front to the back
  typedef struct packed {
    op_e                 op;
    logic [7:0]          rx_byte;
    logic                in_range;
    logic [FRAME_AW-1:0] rd_addr;
  } op_t;

endpackage

// ===== hdl/gbfp_ram.sv =====
// ----------------------------------------------------------------------------
// gbfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gbfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/gbfp_queue.sv =====
// ----------------------------------------------------------------------------
// gbfp_queue
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module gbfp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gbfp_pkg::op_t push_op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output gbfp_pkg::op_t head_o
);
  import gbfp_pkg::*;

  op_t        entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

// ===== hdl/gbfp_front.sv =====
// ----------------------------------------------------------------------------
// gbfp_front
// Input handshake; classifies each beat as a parse byte or a frame read.
// ----------------------------------------------------------------------------
module gbfp_front (
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          req_type_i,
  input  logic [7:0]    rx_byte_i,
  input  logic [7:0]    read_index_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output gbfp_pkg::op_t q_op_o
);
  import gbfp_pkg::*;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_op_o.op       = req_type_i ? OP_READ : OP_PARSE;
    q_op_o.rx_byte  = rx_byte_i;
    q_op_o.in_range = ({24'd0, read_index_i} < 32'(FRAME_BYTES));
    q_op_o.rd_addr  = read_index_i[FRAME_AW-1:0];
  end

endmodule

// ===== hdl/gbfp_back.sv =====
// ----------------------------------------------------------------------------
// gbfp_back
// Parser state machine, checksum, double-buffered held frame and result
// pipeline.
// ----------------------------------------------------------------------------
module gbfp_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gbfp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gbfp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            q_valid_i,
  input  gbfp_pkg::op_t                   q_head_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_o,
  output logic [7:0]                      read_data_o
);
  import gbfp_pkg::*;

  // configuration
  logic [7:0] wanted_class_q, wanted_id_q;

  // parser state
  parse_state_e        state_q, state_d;
  logic [STORE_CW-1:0] store_cnt_q, store_cnt_d;
  logic [15:0]         frame_len_q, frame_len_d;
  logic [15:0]         pay_cnt_q, pay_cnt_d;
  logic [7:0]          sum_a_q, sum_a_d;
  logic [7:0]          sum_b_q, sum_b_d;
  logic [7:0]          cls_q, cls_d;
  logic [7:0]          id_q, id_d;
  logic [7:0]          len_lo_q, len_lo_d;

  // held frame: the active bank is read, the other one fills
  logic active_q, active_d;
  logic held_valid_q, held_valid_d;

  // pipeline
  logic    s1_valid_q, s1_rd_q, s1_sel_q;
  status_e s1_status_q;
  logic    out_valid_q;
  status_e out_status_q;
  logic [7:0] out_data_q;

  logic       s1_adv, pop, parse_pop, read_pop;
  logic [7:0] b, a_next, b_next;
  logic       overflow, accept, wr_en;
  logic [15:0] pay_next;
  status_e    parse_status;
  logic [7:0] rdata0, rdata1;

  assign s1_adv    = !out_valid_q || !out_stall_i;
  assign pop       = q_valid_i && (!s1_valid_q || s1_adv);
  assign q_pop_o   = pop;
  assign parse_pop = pop && (q_head_i.op == OP_PARSE);
  assign read_pop  = pop && (q_head_i.op == OP_READ);

  assign b        = q_head_i.rx_byte;
  assign a_next   = sum_a_q + b;
  assign b_next   = sum_b_q + a_next;
  assign pay_next = pay_cnt_q + 16'd1;
  assign overflow = (store_cnt_q == STORE_CW'(STORE_BYTES));
  assign accept   = FRAME_FITS && (b == sum_b_q) && (cls_q == wanted_class_q) &&
                    (id_q == wanted_id_q) &&
                    (store_cnt_q == STORE_CW'(FRAME_BYTES + HDR_BYTES));
  assign wr_en    = parse_pop && (state_q == PS_PAYLOAD) && !overflow &&
                    (pay_cnt_q < 16'(FRAME_BYTES));

  // next state and parser datapath
  always_comb begin
    state_d      = state_q;
    store_cnt_d  = store_cnt_q;
    frame_len_d  = frame_len_q;
    pay_cnt_d    = pay_cnt_q;
    sum_a_d      = sum_a_q;
    sum_b_d      = sum_b_q;
    cls_d        = cls_q;
    id_d         = id_q;
    len_lo_d     = len_lo_q;
    active_d     = active_q;
    held_valid_d = held_valid_q;
    if (parse_pop) begin
      unique case (state_q)
        PS_SYNC1: begin
          if (b == SYNC_FIRST) begin
            state_d = PS_SYNC2;
          end
        end
        PS_SYNC2: begin
          state_d     = (b == SYNC_SECOND) ? PS_HEADER : PS_SYNC1;
          store_cnt_d = '0;
          frame_len_d = '0;
          pay_cnt_d   = '0;
          sum_a_d     = '0;
          sum_b_d     = '0;
        end
        PS_HEADER, PS_PAYLOAD: begin
          if (overflow) begin
            state_d     = PS_SYNC1;
            store_cnt_d = '0;
            frame_len_d = '0;
            pay_cnt_d   = '0;
            sum_a_d     = '0;
            sum_b_d     = '0;
          end else begin
            store_cnt_d = store_cnt_q + STORE_CW'(1);
            sum_a_d     = a_next;
            sum_b_d     = b_next;
            if (state_q == PS_HEADER) begin
              unique case (store_cnt_q[1:0])
                2'd0: cls_d    = b;
                2'd1: id_d     = b;
                2'd2: len_lo_d = b;
                default: begin
                  frame_len_d = {b, len_lo_q};
                  pay_cnt_d   = '0;
                  state_d     = ({b, len_lo_q} == 16'd0) ? PS_SUM_A : PS_PAYLOAD;
                end
              endcase
            end else begin
              pay_cnt_d = pay_next;
              if (pay_next == frame_len_q) begin
                state_d = PS_SUM_A;
              end
            end
          end
        end
        PS_SUM_A: begin
          if (b == sum_a_q) begin
            state_d = PS_SUM_B;
          end else begin
            state_d     = PS_SYNC1;
            store_cnt_d = '0;
            frame_len_d = '0;
            pay_cnt_d   = '0;
            sum_a_d     = '0;
            sum_b_d     = '0;
          end
        end
        default: begin
          if (state_q == PS_SUM_B && accept) begin
            active_d     = ~active_q;
            held_valid_d = 1'b1;
          end
          state_d     = PS_SYNC1;
          store_cnt_d = '0;
          frame_len_d = '0;
          pay_cnt_d   = '0;
          sum_a_d     = '0;
          sum_b_d     = '0;
        end
      endcase
    end
  end

  // status of a parse beat
  always_comb begin
    parse_status = STAT_PARSING;
    unique case (state_q)
      PS_SYNC1: parse_status = (b == SYNC_FIRST) ? STAT_PARSING : STAT_HUNT;
      PS_SUM_B: parse_status = accept ? STAT_DONE : STAT_PARSING;
      default:  parse_status = STAT_PARSING;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_class_q <= WANTED_CLASS_RST;
      wanted_id_q    <= WANTED_ID_RST;
      state_q        <= PS_SYNC1;
      store_cnt_q    <= '0;
      frame_len_q    <= '0;
      pay_cnt_q      <= '0;
      sum_a_q        <= '0;
      sum_b_q        <= '0;
      active_q       <= 1'b0;
      held_valid_q   <= 1'b0;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WANTED_CLASS: wanted_class_q <= cfg_data_i;
          CFG_WANTED_ID:    wanted_id_q    <= cfg_data_i;
          default: ;
        endcase
      end
      state_q      <= state_d;
      store_cnt_q  <= store_cnt_d;
      frame_len_q  <= frame_len_d;
      pay_cnt_q    <= pay_cnt_d;
      sum_a_q      <= sum_a_d;
      sum_b_q      <= sum_b_d;
      active_q     <= active_d;
      held_valid_q <= held_valid_d;
      if (pop) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cls_q    <= cls_d;
    id_q     <= id_d;
    len_lo_q <= len_lo_d;
    if (pop) begin
      s1_status_q <= read_pop ? STAT_READ : parse_status;
      s1_rd_q     <= read_pop && q_head_i.in_range && held_valid_q;
      s1_sel_q    <= active_q;
    end
    if (s1_adv && s1_valid_q) begin
      out_status_q <= s1_status_q;
      out_data_q   <= s1_rd_q ? (s1_sel_q ? rdata1 : rdata0) : 8'd0;
    end
  end

  gbfp_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (wr_en && active_q),
    .waddr_i (pay_cnt_q[FRAME_AW-1:0]),
    .wdata_i (b),
    .re_i    (read_pop),
    .raddr_i (q_head_i.rd_addr),
    .rdata_o (rdata0)
  );

  gbfp_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (wr_en && !active_q),
    .waddr_i (pay_cnt_q[FRAME_AW-1:0]),
    .wdata_i (b),
    .re_i    (read_pop),
    .raddr_i (q_head_i.rd_addr),
    .rdata_o (rdata1)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign read_data_o = out_data_q;

endmodule

// ===== hdl/gnss_binary_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// gnss_binary_frame_parser_top
// Byte-serial binary GNSS frame parser with a double-buffered held frame.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------
//  in      | in        | in_valid_i/in_stall_o  | req_type, rx_byte, read_index
//  out     | out       | out_valid_o/out_stall_i| status, read_data
//  cfg     | in        | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One beat per cycle sustained while the output is not stalled; each result passes
// through the queue, the execute stage with registered RAM read and the output register.
// The parser updates once per byte; accepted frames swap held-frame
// banks in the same cycle, so no copy sweep is needed.
// Reset clears the parser, config to defaults and marks the held frame empty.
// Output stall backs up into a two-entry queue, then raises in_stall_o.
// ----------------------------------------------------------------------------
module gnss_binary_frame_parser_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            req_type_i,
  input  logic [7:0]                      rx_byte_i,
  input  logic [7:0]                      read_index_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_o,
  output logic [7:0]                      read_data_o,
  input  logic                            cfg_we_i,
  input  logic [gbfp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gbfp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import gbfp_pkg::*;

  op_t  push_op, head_op;
  logic push, full, pop, q_valid;

  gbfp_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .rx_byte_i    (rx_byte_i),
    .read_index_i (read_index_i),
    .q_full_i     (full),
    .q_push_o     (push),
    .q_op_o       (push_op)
  );

  gbfp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (full),
    .pop_i     (pop),
    .valid_o   (q_valid),
    .head_o    (head_op)
  );

  gbfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_head_i    (head_op),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .read_data_o (read_data_o)
  );

endmodule

// ===== tb/gnss_binary_frame_parser_top_tb.sv =====
// ----------------------------------------------------------------------------
// gnss_binary_frame_parser_top_tb
// Drives byte and read beats into the frame parser under several idle/stall
// mixes and wanted class/id settings, predicts every reply in-line and checks
// status and read data beat by beat against the expected-reply queue.
// ----------------------------------------------------------------------------
module gnss_binary_frame_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gbfp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned RANDOM_BEATS   = 4;
  localparam int unsigned DRAIN_CYCLES   = 12;

  typedef struct packed {
    status_e    status;
    logic [7:0] read_data;
  } reply_t;

  typedef enum logic [2:0] {
    FLAW_NONE,
    FLAW_SYNC2,
    FLAW_SUM_A,
    FLAW_SUM_B,
    FLAW_CUT
  } frame_flaw_e;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic                  req_type_i   = 1'b0;
  logic [7:0]            rx_byte_i    = 8'h00;
  logic [7:0]            read_index_i = 8'h00;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic [1:0]            status_o;
  logic [7:0]            read_data_o;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;

  gnss_binary_frame_parser_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .rx_byte_i    (rx_byte_i),
    .read_index_i (read_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .read_data_o  (read_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // parser shadow state
  parse_state_e ps_q;
  int unsigned  store_cnt;
  logic [15:0]  frame_len;
  logic [15:0]  payload_cnt;
  logic [7:0]   fletch_a;
  logic [7:0]   fletch_b;
  logic [7:0]   frame_buf [STORE_BYTES];
  logic [7:0]   held_buf  [FRAME_BYTES];
  logic [7:0]   want_class;
  logic [7:0]   want_id;
  reply_t       pending_replies [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned read_mix_pct   = 0;
  int unsigned hold_left      = 0;
  int unsigned stuck_cycles   = 0;
  int unsigned beat_count     = 0;
  int unsigned read_count     = 0;
  int unsigned taken_count    = 0;
  int unsigned err_count      = 0;

  function automatic void restart_parse();
    ps_q        = PS_SYNC1;
    store_cnt   = 0;
    frame_len   = '0;
    payload_cnt = '0;
    fletch_a    = '0;
    fletch_b    = '0;
  endfunction

  function automatic status_e parse_rx(logic [7:0] b);
    status_e st;
    st = STAT_PARSING;
    case (ps_q)
      PS_SYNC1: begin
        if (b == SYNC_FIRST) ps_q = PS_SYNC2;
        else st = STAT_HUNT;
      end
      PS_SYNC2: begin
        // a bad second sync byte is dropped, not rescanned
        if (b == SYNC_SECOND) begin
          ps_q      = PS_HEADER;
          store_cnt = 0;
          fletch_a  = '0;
          fletch_b  = '0;
        end else begin
          restart_parse();
        end
      end
      PS_HEADER, PS_PAYLOAD: begin
        if (store_cnt >= STORE_BYTES) begin
          restart_parse();
        end else begin
          frame_buf[store_cnt] = b;
          store_cnt++;
          fletch_a = fletch_a + b;
          fletch_b = fletch_b + fletch_a;
          if (ps_q == PS_HEADER) begin
            if (store_cnt == HDR_BYTES) begin
              frame_len   = {frame_buf[3], frame_buf[2]};
              payload_cnt = '0;
              ps_q        = (frame_len == 16'd0) ? PS_SUM_A : PS_PAYLOAD;
            end
          end else begin
            payload_cnt = payload_cnt + 16'd1;
            if (payload_cnt == frame_len) ps_q = PS_SUM_A;
          end
        end
      end
      PS_SUM_A: begin
        if (b == fletch_a) ps_q = PS_SUM_B;
        else restart_parse();
      end
      PS_SUM_B: begin
        if (b == fletch_b && store_cnt == HDR_BYTES + FRAME_BYTES &&
            frame_buf[0] == want_class && frame_buf[1] == want_id) begin
          for (int i = 0; i < FRAME_BYTES; i++) held_buf[i] = frame_buf[HDR_BYTES + i];
          st = STAT_DONE;
        end
        restart_parse();
      end
      default: restart_parse();
    endcase
    return st;
  endfunction

  function automatic void predict_reply(op_e op, logic [7:0] rx, logic [7:0] idx);
    reply_t r;
    if (op == OP_READ) begin
      r.status    = STAT_READ;
      r.read_data = (idx < FRAME_BYTES) ? held_buf[idx] : 8'h00;
      read_count++;
    end else begin
      r.status    = parse_rx(rx);
      r.read_data = 8'h00;
      if (r.status == STAT_DONE) taken_count++;
    end
    pending_replies.push_back(r);
  endfunction

  task automatic send_beat(op_e op, logic [7:0] rx, logic [7:0] idx);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= op;
    rx_byte_i    <= rx;
    read_index_i <= idx;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    predict_reply(op, rx, idx);
    beat_count++;
  endtask

  task automatic read_beat();
    logic [7:0] idx;
    idx = ($urandom_range(1) != 0) ? 8'($urandom_range(FRAME_BYTES - 1)) : 8'($urandom);
    send_beat(OP_READ, 8'($urandom), idx);
  endtask

  task automatic rx_beat(logic [7:0] b);
    if (read_mix_pct != 0 && $urandom_range(99) < read_mix_pct) read_beat();
    send_beat(OP_PARSE, b, 8'($urandom));
  endtask

  task automatic send_frame(logic [7:0] cls, logic [7:0] id, logic [15:0] len,
                            frame_flaw_e flaw);
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  d;
    logic [7:0]  hdr [4];
    int unsigned n_body;
    a   = '0;
    b   = '0;
    hdr = '{cls, id, len[7:0], len[15:8]};
    rx_beat(SYNC_FIRST);
    if (flaw == FLAW_SYNC2) begin
      if ($urandom_range(3) == 0) rx_beat(SYNC_FIRST);
      else rx_beat(SYNC_SECOND ^ 8'(1 << $urandom_range(7)));
      return;
    end
    rx_beat(SYNC_SECOND);
    n_body = HDR_BYTES + len;
    if (flaw == FLAW_CUT) n_body = $urandom_range(n_body - 1);
    for (int i = 0; i < n_body; i++) begin
      d = (i < HDR_BYTES) ? hdr[i] : 8'($urandom);
      a += d;
      b += a;
      rx_beat(d);
    end
    if (flaw == FLAW_CUT) return;
    rx_beat((flaw == FLAW_SUM_A) ? a ^ 8'(1 << $urandom_range(7)) : a);
    rx_beat((flaw == FLAW_SUM_B) ? b ^ 8'(1 << $urandom_range(7)) : b);
  endtask

  function automatic frame_flaw_e pick_flaw();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return FLAW_NONE;
    if (r < 77) return FLAW_SYNC2;
    if (r < 84) return FLAW_SUM_A;
    if (r < 92) return FLAW_SUM_B;
    return FLAW_CUT;
  endfunction

  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_wanted(logic [7:0] cls, logic [7:0] id);
    quiesce();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_WANTED_CLASS;
    cfg_data_i <= cls;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_WANTED_ID;
    cfg_data_i <= id;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    want_class = cls;
    want_id    = id;
  endtask

  // held frame empty after reset, sync hunting, zero-length frames
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    read_mix_pct   = 0;
    send_beat(OP_READ, 8'h00, 8'h00);
    send_beat(OP_READ, 8'hFF, 8'(FRAME_BYTES - 1));
    send_beat(OP_READ, 8'h00, 8'(FRAME_BYTES));
    send_beat(OP_READ, 8'hFF, 8'hFF);
    rx_beat(8'h00);
    rx_beat(SYNC_FIRST);
    rx_beat(8'hFF);
    // second B5 kills the sync, the 0x62 after it is plain hunting
    rx_beat(SYNC_FIRST);
    rx_beat(SYNC_FIRST);
    rx_beat(SYNC_SECOND);
    send_frame(want_class, want_id, 16'd0, FLAW_NONE);
    send_frame(want_class, want_id, 16'd0, FLAW_SUM_A);
  endtask

  task automatic test_store_overflow();
    read_mix_pct = 0;
    rx_beat(SYNC_FIRST);
    rx_beat(SYNC_SECOND);
    rx_beat(want_class);
    rx_beat(want_id);
    rx_beat(8'hFF);
    rx_beat(8'hFF);
    // fill the store, then one byte past it
    repeat (STORE_BYTES - HDR_BYTES + 1) rx_beat(8'($urandom));
    send_frame(want_class, want_id, 16'd0, FLAW_NONE);
  endtask

  task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct);
    int unsigned start;
    int unsigned sel;
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [15:0] len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    read_mix_pct   = 8;
    start          = beat_count;
    while (beat_count - start < RANDOM_BEATS) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        send_frame(want_class, want_id, 16'(FRAME_BYTES), pick_flaw());
      end else if (sel < 62) begin
        cls = ($urandom_range(1) != 0) ? want_class : 8'($urandom);
        id  = ($urandom_range(1) != 0) ? want_id : 8'($urandom);
        send_frame(cls, id, 16'($urandom_range(6)), pick_flaw());
      end else if (sel < 72) begin
        // full-size frame that misses on exactly one of class, id, length
        cls = want_class;
        id  = want_id;
        len = 16'(FRAME_BYTES);
        case ($urandom_range(2))
          0: cls = cls ^ 8'(1 << $urandom_range(7));
          1: id = id ^ 8'(1 << $urandom_range(7));
          default: len = ($urandom_range(1) != 0) ? len + 16'd1 : len - 16'd1;
        endcase
        send_frame(cls, id, len, FLAW_NONE);
      end else if (sel < 86) begin
        repeat ($urandom_range(6, 1))
          rx_beat(($urandom_range(3) == 0) ? SYNC_FIRST : 8'($urandom));
      end else begin
        repeat ($urandom_range(4, 1)) read_beat();
      end
    end
  endtask

  // output held off while beats keep coming, then a pause until all replies land
  task automatic test_backpressure();
    quiesce();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    read_mix_pct   = 0;
    hold_left     <= HOLD_CYCLES;
    send_frame(want_class, want_id, 16'(FRAME_BYTES), FLAW_NONE);
    quiesce();
    repeat (8) read_beat();
  endtask

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : reply_check
    reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_replies.size() == 0) begin
        $error("reply with none pending: status %0d read_data 0x%02h", status_o, read_data_o);
        err_count++;
      end else begin
        want = pending_replies.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          err_count++;
        end
        if (read_data_o !== want.read_data) begin
          $error("read_data: expected 0x%02h, got 0x%02h", want.read_data, read_data_o);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("gnss_binary_frame_parser_top_tb: errors");
      $finish;
    end
  end

  initial begin
    restart_parse();
    want_class = WANTED_CLASS_RST;
    want_id    = WANTED_ID_RST;
    foreach (held_buf[i]) held_buf[i] = 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_store_overflow();
    test_random_traffic(0, 0);
    write_wanted(8'h00, 8'hFF);
    test_random_traffic(55, 0);
    write_wanted(8'hFF, 8'h00);
    test_random_traffic(0, 55);
    write_wanted(8'($urandom), 8'($urandom));
    test_random_traffic(34, 34);
    test_backpressure();

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("run: %0d beats sent, %0d of them reads, %0d frames latched as held",
             beat_count, read_count, taken_count);
    $display("run: reset and extreme class/id settings, store overflow, long output hold");
    if (err_count == 0)
      $display("gnss_binary_frame_parser_top_tb: clean");
    else
      $display("gnss_binary_frame_parser_top_tb: errors");
    $finish;
  end

endmodule
